>>> rtl/smam_pkg.sv
// ----------------------------------------------------------------------------
// smam_pkg: shared definitions of the small matrix add and multiply block
// Field widths, mode, status and register codes, and the store control word.
// ----------------------------------------------------------------------------
package smam_pkg;

    // Field widths of the stream words and the configuration channel.
    localparam int MODE_W      = 3;
    localparam int IDX_W       = 4;
    localparam int VALUE_W     = 32;
    localparam int STATUS_W    = 2;
    localparam int DIM_W       = 5;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 5;
    localparam int IN_DATA_W   = 2 * IDX_W + VALUE_W;
    localparam int OUT_DATA_W  = 2 * IDX_W + VALUE_W;

    // Input word modes.
    localparam logic [MODE_W-1:0] MODE_WRITE_A = 3'd0;
    localparam logic [MODE_W-1:0] MODE_WRITE_B = 3'd1;
    localparam logic [MODE_W-1:0] MODE_READ_A  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_READ_B  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_COMPUTE = 3'd4;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_OOB       = 2'd1;
    localparam logic [STATUS_W-1:0] ST_MISMATCH  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_TOO_LARGE = 2'd3;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] CFG_OPERATION = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_A_ROWS    = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_A_COLS    = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_B_ROWS    = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_B_COLS    = 3'd4;

    // Operation register values.
    localparam logic OP_ADD = 1'b0;
    localparam logic OP_MUL = 1'b1;

    // Control word of one matrix store.
    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } smam_mem_ctl_t;

endpackage

>>> rtl/smam_store.sv
// ----------------------------------------------------------------------------
// smam_store: one matrix element store
// Single-port memory with a registered read and per-entry valid bits, so that
// an entry not written since reset reads as zero.
// ----------------------------------------------------------------------------
module smam_store #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 32,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  smam_pkg::smam_mem_ctl_t ctl,
    input  logic [AW-1:0]           addr,
    input  logic [WIDTH-1:0]        wdata,
    output logic [WIDTH-1:0]        rdata
);
    import smam_pkg::*;

    logic [WIDTH-1:0] mem [DEPTH];
    logic [DEPTH-1:0] valid_reg;
    logic [WIDTH-1:0] rd_data_reg;
    logic             rd_ok_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem[addr] <= wdata;
        end
        if (ctl.rd_en)
        begin
            rd_data_reg <= mem[addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            rd_ok_reg <= 1'b0;
        end
        else
        begin
            if (ctl.wr_en)
            begin
                valid_reg[addr] <= 1'b1;
            end
            if (ctl.rd_en)
            begin
                rd_ok_reg <= valid_reg[addr];
            end
        end
    end

    assign rdata = rd_ok_reg ? rd_data_reg : '0;

endmodule

>>> rtl/small_matrix_add_multiply.sv
// ----------------------------------------------------------------------------
// small_matrix_add_multiply: small integer matrix adder and multiplier
// Holds matrices A and B, serves element writes and reads, and streams out
// A+B or AxB element by element in row-major order.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Handshake                       Word
// s_axis    in         s_axis_tvalid / s_axis_tready   tuser mode, tdata position, value
// m_axis    out        m_axis_tvalid / m_axis_tready   tuser status, tdata position, value
// cfg       in         cfg_valid / cfg_ready           cfg_index, cfg_data
//
// An element write or read passes an access and a result step before its
// result enters the output register. A compute runs a check step, then per
// element, for addition, a read and an add step, or, for multiplication, per
// inner term a read step and one step per B digit on the one shared multiplier,
// then a drain step; ND, the digit count, is 1 for ELEMENT_WIDTH up to 32,
// else ceil(ELEMENT_WIDTH / 16). The input side is ready only while the
// sequencer idles. Reset clears both stores through valid bits at once and
// loads the register defaults (multiply, 4x4 shapes). A stalled output word
// holds the sequencer at its emit step; configuration writes are always taken.
//
module small_matrix_add_multiply #(
    parameter int MAX_ELEMENTS  = 16,
    parameter int ELEMENT_WIDTH = 32
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // Input words.
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // row_index [3:0], col_index [7:4], in_value [39:8]
    input  logic [smam_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    // mode [2:0]
    input  logic [smam_pkg::MODE_W-1:0]       s_axis_tuser,
    // Result words.
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // out_row [3:0], out_col [7:4], out_value [39:8]
    output logic [smam_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
    // status [1:0]
    output logic [smam_pkg::STATUS_W-1:0]     m_axis_tuser,
    output logic                              m_axis_tlast,
    // Configuration writes.
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [smam_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [smam_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import smam_pkg::*;

    localparam int W   = ELEMENT_WIDTH;
    // Store address width and the width of element counts up to MAX_ELEMENTS.
    localparam int AW  = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
    localparam int CW  = $clog2(MAX_ELEMENTS + 1);
    // Linear pointers into the stores; wide enough for any 5-bit shape walk.
    localparam int PW  = 11;
    // The multiplier takes the B operand ND digits of DW bits, one per cycle.
    localparam int ND  = (W <= 32) ? 1 : (W + 15) / 16;
    localparam int DW  = (W + ND - 1) / ND;
    localparam int DCW = (ND > 1) ? $clog2(ND) : 1;
    localparam logic [9:0] MAX_SIZE = 10'(MAX_ELEMENTS);

    typedef enum logic [9:0] {
        S_IDLE   = 10'b0000000001,
        S_ACCESS = 10'b0000000010,
        S_SINGLE = 10'b0000000100,
        S_CCHK   = 10'b0000001000,
        S_ELEM   = 10'b0000010000,
        S_RD     = 10'b0000100000,
        S_ADD    = 10'b0001000000,
        S_MUL    = 10'b0010000000,
        S_DRAIN  = 10'b0100000000,
        S_OUT    = 10'b1000000000
    } state_t;

    state_t state_reg, state_next;

    // Configuration registers.
    logic             op_reg, op_next;
    logic [DIM_W-1:0] a_rows_reg, a_rows_next;
    logic [DIM_W-1:0] a_cols_reg, a_cols_next;
    logic [DIM_W-1:0] b_rows_reg, b_rows_next;
    logic [DIM_W-1:0] b_cols_reg, b_cols_next;

    // Latched input word.
    logic [IDX_W-1:0]   row_reg, row_next;
    logic [IDX_W-1:0]   col_reg, col_next;
    logic [VALUE_W-1:0] value_reg, value_next;
    logic               is_b_reg, is_b_next;
    logic               is_write_reg, is_write_next;

    // Single-result bookkeeping.
    logic [STATUS_W-1:0] status_reg, status_next;
    logic                single_read_reg, single_read_next;

    // Compute walk.
    logic [DIM_W-1:0] i_reg, i_next;
    logic [DIM_W-1:0] j_reg, j_next;
    logic [DIM_W-1:0] k_reg, k_next;
    logic [DCW-1:0]   d_reg, d_next;
    logic [CW-1:0]    n_reg, n_next;
    logic [CW-1:0]    count_reg, count_next;
    logic [DIM_W-1:0] ocols_reg, ocols_next;
    logic [PW-1:0]    a_base_reg, a_base_next;
    logic [PW-1:0]    ia_reg, ia_next;
    logic [PW-1:0]    ib_reg, ib_next;

    // Shared arithmetic unit.
    logic [W-1:0]    acc_reg, acc_next;
    logic [W-1:0]    prod_reg, prod_next;
    logic            prod_valid_reg, prod_valid_next;
    logic [DW-1:0]   b_digit;
    logic [W+DW-1:0] partial;
    logic [W-1:0]    add_x;
    logic [W-1:0]    add_y;
    logic [W-1:0]    sum;

    // Output register.
    logic                out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0] out_status_reg;
    logic [IDX_W-1:0]    out_row_reg;
    logic [IDX_W-1:0]    out_col_reg;
    logic [VALUE_W-1:0]  out_value_reg;
    logic                out_last_reg;

    logic                slot_free;
    logic                emit;
    logic [STATUS_W-1:0] emit_status;
    logic [IDX_W-1:0]    emit_row;
    logic [IDX_W-1:0]    emit_col;
    logic                emit_last;
    logic [W-1:0]        emit_value_w;
    logic [VALUE_W-1:0]  emit_value;

    // Stores.
    smam_mem_ctl_t a_ctl, b_ctl;
    logic [AW-1:0] a_addr, b_addr;
    logic [W-1:0]  wr_value;
    logic [W-1:0]  a_rd, b_rd;
    logic [W-1:0]  sel_rd;

    // Shape checks.
    logic [DIM_W-1:0] sel_rows, sel_cols;
    logic [9:0]       sel_size;
    logic [9:0]       acc_lin;
    logic             acc_big, acc_oob;
    logic [9:0]       a_size, b_size, res_size;
    logic [DIM_W-1:0] res_cols;
    logic             mismatch, too_large;
    logic [DIM_W-1:0] j_inc;
    logic [CW-1:0]    n_inc;

    smam_store #(
        .DEPTH (MAX_ELEMENTS),
        .WIDTH (W),
        .AW    (AW)
    ) u_store_a (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (a_ctl),
        .addr  (a_addr),
        .wdata (wr_value),
        .rdata (a_rd)
    );

    smam_store #(
        .DEPTH (MAX_ELEMENTS),
        .WIDTH (W),
        .AW    (AW)
    ) u_store_b (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (b_ctl),
        .addr  (b_addr),
        .wdata (wr_value),
        .rdata (b_rd)
    );

    // Input values are sign-extended or cut to the element width, and
    // elements leave sign-extended or cut to 32 bits.
    generate
        if (W > VALUE_W)
        begin : g_wide
            assign wr_value   = {{(W - VALUE_W){value_reg[VALUE_W-1]}}, value_reg};
            assign emit_value = emit_value_w[VALUE_W-1:0];
        end
        else if (W == VALUE_W)
        begin : g_equal
            assign wr_value   = value_reg;
            assign emit_value = emit_value_w;
        end
        else
        begin : g_narrow
            assign wr_value   = value_reg[W-1:0];
            assign emit_value = {{(VALUE_W - W){emit_value_w[W-1]}}, emit_value_w};
        end
    endgenerate

    // Multiplier: A times one digit of B, shifted into place, low W bits kept.
    assign b_digit = DW'(b_rd >> (d_reg * DW));
    assign partial = a_rd * b_digit;
    assign prod_next = (state_reg == S_MUL) ? (partial[W-1:0] << (d_reg * DW)) : prod_reg;

    // One adder serves both the element-wise sum and the accumulation.
    assign add_x = prod_valid_reg ? acc_reg  : a_rd;
    assign add_y = prod_valid_reg ? prod_reg : b_rd;
    assign sum   = add_x + add_y;

    // Element access checks against the shape of the addressed matrix.
    assign sel_rows = is_b_reg ? b_rows_reg : a_rows_reg;
    assign sel_cols = is_b_reg ? b_cols_reg : a_cols_reg;
    assign sel_size = sel_rows * sel_cols;
    assign acc_big  = sel_size > MAX_SIZE;
    assign acc_oob  = ({1'b0, row_reg} >= sel_rows) || ({1'b0, col_reg} >= sel_cols);
    assign acc_lin  = row_reg * sel_cols + 10'(col_reg);
    assign sel_rd   = is_b_reg ? b_rd : a_rd;

    // Compute checks.
    assign a_size    = a_rows_reg * a_cols_reg;
    assign b_size    = b_rows_reg * b_cols_reg;
    assign res_cols  = (op_reg == OP_ADD) ? a_cols_reg : b_cols_reg;
    assign res_size  = a_rows_reg * res_cols;
    assign mismatch  = (op_reg == OP_ADD) ?
                       ((a_rows_reg != b_rows_reg) || (a_cols_reg != b_cols_reg)) :
                       (a_cols_reg != b_rows_reg);
    assign too_large = (a_size > MAX_SIZE) || (b_size > MAX_SIZE) || (res_size > MAX_SIZE);

    assign j_inc = j_reg + 5'd1;
    assign n_inc = n_reg + CW'(1);

    assign slot_free     = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = (state_reg == S_IDLE);
    assign cfg_ready     = 1'b1;

    always_comb
    begin
        state_next       = state_reg;
        op_next          = op_reg;
        a_rows_next      = a_rows_reg;
        a_cols_next      = a_cols_reg;
        b_rows_next      = b_rows_reg;
        b_cols_next      = b_cols_reg;
        row_next         = row_reg;
        col_next         = col_reg;
        value_next       = value_reg;
        is_b_next        = is_b_reg;
        is_write_next    = is_write_reg;
        status_next      = status_reg;
        single_read_next = single_read_reg;
        i_next           = i_reg;
        j_next           = j_reg;
        k_next           = k_reg;
        d_next           = d_reg;
        n_next           = n_reg;
        count_next       = count_reg;
        ocols_next       = ocols_reg;
        a_base_next      = a_base_reg;
        ia_next          = ia_reg;
        ib_next          = ib_reg;
        prod_valid_next  = 1'b0;
        acc_next         = prod_valid_reg ? sum : acc_reg;
        a_ctl            = '0;
        b_ctl            = '0;
        a_addr           = acc_lin[AW-1:0];
        b_addr           = acc_lin[AW-1:0];
        emit             = 1'b0;
        emit_status      = ST_OK;
        emit_row         = i_reg[IDX_W-1:0];
        emit_col         = j_reg[IDX_W-1:0];
        emit_last        = 1'b1;
        emit_value_w     = acc_reg;

        if (cfg_valid)
        begin
            case (cfg_index)
                CFG_OPERATION: op_next     = cfg_data[0];
                CFG_A_ROWS:    a_rows_next = cfg_data;
                CFG_A_COLS:    a_cols_next = cfg_data;
                CFG_B_ROWS:    b_rows_next = cfg_data;
                CFG_B_COLS:    b_cols_next = cfg_data;
                default:       ;
            endcase
        end

        case (state_reg)
            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    row_next      = s_axis_tdata[IDX_W-1:0];
                    col_next      = s_axis_tdata[2*IDX_W-1:IDX_W];
                    value_next    = s_axis_tdata[2*IDX_W+VALUE_W-1:2*IDX_W];
                    is_b_next     = (s_axis_tuser == MODE_WRITE_B) ||
                                    (s_axis_tuser == MODE_READ_B);
                    is_write_next = (s_axis_tuser == MODE_WRITE_A) ||
                                    (s_axis_tuser == MODE_WRITE_B);
                    if (s_axis_tuser inside {MODE_WRITE_A, MODE_WRITE_B,
                                             MODE_READ_A, MODE_READ_B})
                    begin
                        state_next = S_ACCESS;
                    end
                    else if (s_axis_tuser == MODE_COMPUTE)
                    begin
                        state_next = S_CCHK;
                    end
                end
            end

            S_ACCESS:
            begin
                if (acc_big)
                begin
                    status_next = ST_TOO_LARGE;
                end
                else if (acc_oob)
                begin
                    status_next = ST_OOB;
                end
                else
                begin
                    status_next = ST_OK;
                    if (is_b_reg)
                    begin
                        b_ctl.wr_en = is_write_reg;
                        b_ctl.rd_en = !is_write_reg;
                    end
                    else
                    begin
                        a_ctl.wr_en = is_write_reg;
                        a_ctl.rd_en = !is_write_reg;
                    end
                end
                single_read_next = !acc_big && !acc_oob && !is_write_reg;
                state_next       = S_SINGLE;
            end

            S_SINGLE:
            begin
                emit_status  = status_reg;
                emit_row     = row_reg;
                emit_col     = col_reg;
                emit_value_w = single_read_reg ? sel_rd : '0;
                if (slot_free)
                begin
                    emit       = 1'b1;
                    state_next = S_IDLE;
                end
            end

            S_CCHK:
            begin
                // Compute errors report at position zero.
                row_next         = '0;
                col_next         = '0;
                single_read_next = 1'b0;
                i_next           = '0;
                j_next           = '0;
                n_next           = '0;
                a_base_next      = '0;
                ocols_next       = res_cols;
                count_next       = res_size[CW-1:0];
                if (mismatch)
                begin
                    status_next = ST_MISMATCH;
                    state_next  = S_SINGLE;
                end
                else if (too_large)
                begin
                    status_next = ST_TOO_LARGE;
                    state_next  = S_SINGLE;
                end
                else if (res_size == 10'd0)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_ELEM;
                end
            end

            S_ELEM:
            begin
                acc_next = '0;
                k_next   = '0;
                ia_next  = a_base_reg;
                ib_next  = PW'(j_reg);
                if ((op_reg == OP_MUL) && (a_cols_reg == '0))
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    state_next = S_RD;
                end
            end

            S_RD:
            begin
                a_ctl.rd_en = 1'b1;
                b_ctl.rd_en = 1'b1;
                if (op_reg == OP_ADD)
                begin
                    a_addr     = n_reg[AW-1:0];
                    b_addr     = n_reg[AW-1:0];
                    state_next = S_ADD;
                end
                else
                begin
                    a_addr     = ia_reg[AW-1:0];
                    b_addr     = ib_reg[AW-1:0];
                    ia_next    = ia_reg + PW'(1);
                    ib_next    = ib_reg + PW'(b_cols_reg);
                    k_next     = k_reg + 5'd1;
                    d_next     = '0;
                    state_next = S_MUL;
                end
            end

            S_ADD:
            begin
                acc_next   = sum;
                state_next = S_OUT;
            end

            S_MUL:
            begin
                prod_valid_next = 1'b1;
                if (d_reg == DCW'(ND - 1))
                begin
                    d_next     = '0;
                    state_next = (k_reg == a_cols_reg) ? S_DRAIN : S_RD;
                end
                else
                begin
                    d_next = d_reg + DCW'(1);
                end
            end

            S_DRAIN:
            begin
                state_next = S_OUT;
            end

            S_OUT:
            begin
                emit_last = (n_inc == count_reg);
                if (slot_free)
                begin
                    emit   = 1'b1;
                    n_next = n_inc;
                    if (j_inc == ocols_reg)
                    begin
                        j_next      = '0;
                        i_next      = i_reg + 5'd1;
                        a_base_next = a_base_reg + PW'(a_cols_reg);
                    end
                    else
                    begin
                        j_next = j_inc;
                    end
                    state_next = (n_inc == count_reg) ? S_IDLE : S_ELEM;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // Control state and configuration.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            op_reg         <= OP_MUL;
            a_rows_reg     <= 5'd4;
            a_cols_reg     <= 5'd4;
            b_rows_reg     <= 5'd4;
            b_cols_reg     <= 5'd4;
            out_valid_reg  <= 1'b0;
            prod_valid_reg <= 1'b0;
            i_reg          <= '0;
            j_reg          <= '0;
            k_reg          <= '0;
            d_reg          <= '0;
            n_reg          <= '0;
            acc_reg        <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            op_reg         <= op_next;
            a_rows_reg     <= a_rows_next;
            a_cols_reg     <= a_cols_next;
            b_rows_reg     <= b_rows_next;
            b_cols_reg     <= b_cols_next;
            out_valid_reg  <= out_valid_next;
            prod_valid_reg <= prod_valid_next;
            i_reg          <= i_next;
            j_reg          <= j_next;
            k_reg          <= k_next;
            d_reg          <= d_next;
            n_reg          <= n_next;
            acc_reg        <= acc_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        row_reg         <= row_next;
        col_reg         <= col_next;
        value_reg       <= value_next;
        is_b_reg        <= is_b_next;
        is_write_reg    <= is_write_next;
        status_reg      <= status_next;
        single_read_reg <= single_read_next;
        count_reg       <= count_next;
        ocols_reg       <= ocols_next;
        a_base_reg      <= a_base_next;
        ia_reg          <= ia_next;
        ib_reg          <= ib_next;
        prod_reg        <= prod_next;
        if (emit)
        begin
            out_status_reg <= emit_status;
            out_row_reg    <= emit_row;
            out_col_reg    <= emit_col;
            out_value_reg  <= emit_value;
            out_last_reg   <= emit_last;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_value_reg, out_col_reg, out_row_reg};
    assign m_axis_tuser  = out_status_reg;
    assign m_axis_tlast  = out_last_reg;

endmodule

>>> verif/small_matrix_add_multiply_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// small_matrix_add_multiply_test: self-checking bench of the matrix block
// A stimulus table exercises reset contents, bounds, shape errors and size
// extremes. Random phases then load A and B under fresh shapes, compute and
// read back. Every result word is checked against an in-bench matrix model or a hand-typed result.
// ----------------------------------------------------------------------------
module small_matrix_add_multiply_test;

    import smam_pkg::*;

    localparam int     MAX_ELEMENTS     = 16;
    localparam int     RANDOM_WORDS     = 210;
    // Idle cycles after the last result before touching the registers; this
    // covers spare modes and empty computes, which finish without a result.
    localparam int     SETTLE_CYCLES    = 40;
    localparam int     LONG_HOLD_CYCLES = 400;
    localparam int     PRINT_LIMIT      = 40;
    localparam longint WATCHDOG_NS      = 64'd15_000_000;

    // Modes the block must ignore.
    localparam logic [MODE_W-1:0] MODE_SPARE_5 = 3'd5;
    localparam logic [MODE_W-1:0] MODE_SPARE_6 = 3'd6;
    localparam logic [MODE_W-1:0] MODE_SPARE_7 = 3'd7;

    typedef struct packed {
        logic [MODE_W-1:0]  mode;
        logic [IDX_W-1:0]   row;
        logic [IDX_W-1:0]   col;
        logic [VALUE_W-1:0] value;
    } matrix_cmd_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [IDX_W-1:0]    row;
        logic [IDX_W-1:0]    col;
        logic [VALUE_W-1:0]  value;
        logic                last;
    } matrix_word_t;

    typedef enum logic { STEP_WORD, STEP_REG } step_kind_t;

    // One line of the directed table: either an input word or a register
    // write. A word may carry a result typed in by hand.
    typedef struct packed {
        step_kind_t             kind;
        matrix_cmd_t            cmd;
        logic [CFG_INDEX_W-1:0] reg_index;
        logic [CFG_DATA_W-1:0]  reg_value;
        logic                   typed;
        matrix_word_t           typed_word;
    } plan_row_t;

    logic                   clk;
    logic                   rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_DATA_W-1:0]   s_axis_tdata;
    logic [MODE_W-1:0]      s_axis_tuser;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_DATA_W-1:0]  m_axis_tdata;
    logic [STATUS_W-1:0]    m_axis_tuser;
    logic                   m_axis_tlast;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    // Bench copy of the matrix stores and the shape registers.
    logic [VALUE_W-1:0] a_mem [MAX_ELEMENTS];
    logic [VALUE_W-1:0] b_mem [MAX_ELEMENTS];
    logic               op_cfg;
    int unsigned        a_rows_cfg, a_cols_cfg, b_rows_cfg, b_cols_cfg;

    matrix_word_t awaited_results [$];
    plan_row_t    directed_plan [$];

    int error_count    = 0;
    int results_seen   = 0;
    int words_accepted = 0;

    // Handshake between the stimulus and the result sink.
    bit sink_steady       = 1'b0;
    bit sink_hold_request = 1'b0;

    small_matrix_add_multiply uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Matrix model
    // ------------------------------------------------------------------------

    function automatic void await_word(logic [STATUS_W-1:0] status,
                                       logic [IDX_W-1:0] row, logic [IDX_W-1:0] col,
                                       logic [VALUE_W-1:0] value, logic last);
        matrix_word_t w;
        w.status = status;
        w.row    = row;
        w.col    = col;
        w.value  = value;
        w.last   = last;
        awaited_results.push_back(w);
    endfunction

    // Works out the result words of one accepted input word and applies its
    // store writes. Element arithmetic is 32 bits wide, so sums and products
    // wrap exactly like the block's.
    function automatic void compute_matrix_results(matrix_cmd_t cmd);
        int unsigned        rows, cols, idx, orows, ocols, count, n, ia, ib;
        bit                 use_b, shape_bad;
        logic [VALUE_W-1:0] acc;
        logic [VALUE_W-1:0] readback;
        if (cmd.mode == MODE_WRITE_A || cmd.mode == MODE_WRITE_B ||
            cmd.mode == MODE_READ_A || cmd.mode == MODE_READ_B)
        begin
            use_b = (cmd.mode == MODE_WRITE_B || cmd.mode == MODE_READ_B);
            rows  = use_b ? b_rows_cfg : a_rows_cfg;
            cols  = use_b ? b_cols_cfg : a_cols_cfg;
            if (rows * cols > MAX_ELEMENTS)
                await_word(ST_TOO_LARGE, cmd.row, cmd.col, '0, 1'b1);
            else if (cmd.row >= rows || cmd.col >= cols)
                await_word(ST_OOB, cmd.row, cmd.col, '0, 1'b1);
            else
            begin
                idx = cmd.row * cols + cmd.col;
                readback = '0;
                if (cmd.mode == MODE_WRITE_A)
                    a_mem[idx] = cmd.value;
                else if (cmd.mode == MODE_WRITE_B)
                    b_mem[idx] = cmd.value;
                else if (cmd.mode == MODE_READ_A)
                    readback = a_mem[idx];
                else
                    readback = b_mem[idx];
                await_word(ST_OK, cmd.row, cmd.col, readback, 1'b1);
            end
        end
        else if (cmd.mode == MODE_COMPUTE)
        begin
            orows = a_rows_cfg;
            if (op_cfg == OP_ADD)
            begin
                shape_bad = (a_rows_cfg != b_rows_cfg) || (a_cols_cfg != b_cols_cfg);
                ocols     = a_cols_cfg;
            end
            else
            begin
                shape_bad = (a_cols_cfg != b_rows_cfg);
                ocols     = b_cols_cfg;
            end
            count = orows * ocols;
            // The shape check wins over the size check.
            if (shape_bad)
                await_word(ST_MISMATCH, '0, '0, '0, 1'b1);
            else if (a_rows_cfg * a_cols_cfg > MAX_ELEMENTS ||
                     b_rows_cfg * b_cols_cfg > MAX_ELEMENTS || count > MAX_ELEMENTS)
                await_word(ST_TOO_LARGE, '0, '0, '0, 1'b1);
            else
            begin
                n = 0;
                for (int unsigned i = 0; i < orows; i++)
                begin
                    for (int unsigned j = 0; j < ocols; j++)
                    begin
                        if (op_cfg == OP_ADD)
                        begin
                            idx = (i * ocols + j) % MAX_ELEMENTS;
                            acc = a_mem[idx] + b_mem[idx];
                        end
                        else
                        begin
                            acc = '0;
                            for (int unsigned k = 0; k < a_cols_cfg; k++)
                            begin
                                ia  = (i * a_cols_cfg + k) % MAX_ELEMENTS;
                                ib  = (k * b_cols_cfg + j) % MAX_ELEMENTS;
                                acc = acc + a_mem[ia] * b_mem[ib];
                            end
                        end
                        n++;
                        await_word(ST_OK, i[IDX_W-1:0], j[IDX_W-1:0], acc, n == count);
                    end
                end
            end
        end
        // Spare modes leave no trace.
    endfunction

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------

    function automatic matrix_cmd_t make_cmd(int unsigned mode, int unsigned row,
                                             int unsigned col, logic [VALUE_W-1:0] value);
        matrix_cmd_t c;
        c.mode  = mode[MODE_W-1:0];
        c.row   = row[IDX_W-1:0];
        c.col   = col[IDX_W-1:0];
        c.value = value;
        return c;
    endfunction

    // Mostly back-to-back or short gaps, now and then a long one.
    function automatic int pick_gap(bit steady);
        int roll;
        if (steady)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 50)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Element values lean toward the corners of the signed range.
    function automatic logic [VALUE_W-1:0] pick_value();
        logic [31:0] r;
        r = $urandom;
        case ($urandom_range(0, 7))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'hFFFF_FFFF;
            3:       return {{28{r[3]}}, r[3:0]};
            default: return r;
        endcase
    endfunction

    // Offers one input word after a gap of the given length. Valid stays high
    // after acceptance, so the next call with no gap continues back to back;
    // any other next step lowers it at the following falling edge.
    task automatic send_word(matrix_cmd_t cmd, int gap);
        if (gap > 0)
        begin
            @(negedge clk);
            s_axis_tvalid = 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        s_axis_tuser  = cmd.mode;
        s_axis_tdata  = {cmd.value, cmd.col, cmd.row};
        s_axis_tvalid = 1'b1;
        do @(posedge clk); while (!s_axis_tready);
        compute_matrix_results(cmd);
        if (cmd.mode <= MODE_COMPUTE)
            words_accepted++;
    endtask

    // Pauses the input until every awaited result has arrived, then lets the
    // block settle.
    task automatic drain_block();
        @(negedge clk);
        s_axis_tvalid = 1'b0;
        while (awaited_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(logic [CFG_INDEX_W-1:0] idx, int unsigned value);
        @(negedge clk);
        cfg_index = idx;
        cfg_data  = value[CFG_DATA_W-1:0];
        cfg_valid = 1'b1;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            CFG_OPERATION: op_cfg     = cfg_data[0];
            CFG_A_ROWS:    a_rows_cfg = cfg_data;
            CFG_A_COLS:    a_cols_cfg = cfg_data;
            CFG_B_ROWS:    b_rows_cfg = cfg_data;
            CFG_B_COLS:    b_cols_cfg = cfg_data;
            default: ;
        endcase
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Directed table rows
    // ------------------------------------------------------------------------

    function automatic void plan_reg(logic [CFG_INDEX_W-1:0] idx, int unsigned value);
        plan_row_t p;
        p           = '0;
        p.kind      = STEP_REG;
        p.reg_index = idx;
        p.reg_value = value[CFG_DATA_W-1:0];
        directed_plan.push_back(p);
    endfunction

    function automatic void plan_word(logic [MODE_W-1:0] mode, int unsigned row,
                                      int unsigned col, logic [VALUE_W-1:0] value);
        plan_row_t p;
        p      = '0;
        p.kind = STEP_WORD;
        p.cmd  = make_cmd(mode, row, col, value);
        directed_plan.push_back(p);
    endfunction

    function automatic void plan_checked(logic [MODE_W-1:0] mode, int unsigned row,
                                         int unsigned col, logic [VALUE_W-1:0] value,
                                         logic [STATUS_W-1:0] status, int unsigned out_row,
                                         int unsigned out_col, logic [VALUE_W-1:0] out_value);
        plan_row_t p;
        p                   = '0;
        p.kind              = STEP_WORD;
        p.cmd               = make_cmd(mode, row, col, value);
        p.typed             = 1'b1;
        p.typed_word.status = status;
        p.typed_word.row    = out_row[IDX_W-1:0];
        p.typed_word.col    = out_col[IDX_W-1:0];
        p.typed_word.value  = out_value;
        p.typed_word.last   = 1'b1;
        directed_plan.push_back(p);
    endfunction

    // ------------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------------

    task automatic flag_mismatch(string what, logic [63:0] seen_v, logic [63:0] want_v);
        error_count++;
        if (error_count <= PRINT_LIMIT)
            $display("%0t ns: result word %0d, %s is %0h, awaited %0h",
                     $time, results_seen, what, seen_v, want_v);
    endtask

    // Result words are sampled at the rising edge, before the block updates.
    always @(posedge clk)
    begin : result_check
        matrix_word_t seen;
        matrix_word_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            seen.status = m_axis_tuser;
            seen.row    = m_axis_tdata[IDX_W-1:0];
            seen.col    = m_axis_tdata[2*IDX_W-1:IDX_W];
            seen.value  = m_axis_tdata[OUT_DATA_W-1:2*IDX_W];
            seen.last   = m_axis_tlast;
            results_seen++;
            if (awaited_results.size() == 0)
                flag_mismatch("word with nothing awaited", seen, '0);
            else
            begin
                want = awaited_results.pop_front();
                if (seen.status !== want.status)
                    flag_mismatch("status", seen.status, want.status);
                if (seen.row !== want.row)
                    flag_mismatch("row", seen.row, want.row);
                if (seen.col !== want.col)
                    flag_mismatch("column", seen.col, want.col);
                if (seen.value !== want.value)
                    flag_mismatch("value", seen.value, want.value);
                if (seen.last !== want.last)
                    flag_mismatch("last flag", seen.last, want.last);
            end
        end
    end

    // The result sink stalls at random. A hold request from the stimulus
    // keeps it off for a long stretch so that the block backs up into its
    // input; in steady phases it never stalls.
    initial
    begin : result_sink
        int stall_left;
        stall_left    = 0;
        m_axis_tready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (sink_hold_request)
            begin
                sink_hold_request = 1'b0;
                stall_left        = LONG_HOLD_CYCLES;
            end
            if (stall_left > 0)
            begin
                m_axis_tready = 1'b0;
                stall_left--;
            end
            else
            begin
                m_axis_tready = 1'b1;
                if (!sink_steady && $urandom_range(0, 2) == 0)
                    stall_left = pick_gap(1'b0);
            end
        end
    end

    initial
    begin : watchdog
        #(WATCHDOG_NS);
        $display("== FAIL ==");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------

    initial
    begin : stimulus
        plan_row_t   step;
        int unsigned shape_kind, op, ar, ac, br, bc, rows, cols, reads, phase;
        bit          steady, use_b;

        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        cfg_valid     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        rst_n         = 1'b0;

        // Model state after reset: zero stores, multiply, 4x4 shapes.
        for (int i = 0; i < MAX_ELEMENTS; i++)
        begin
            a_mem[i] = '0;
            b_mem[i] = '0;
        end
        op_cfg     = OP_MUL;
        a_rows_cfg = 4;
        a_cols_cfg = 4;
        b_rows_cfg = 4;
        b_cols_cfg = 4;

        // Reset contents, bounds on rows and on columns, and signed corners.
        plan_checked(MODE_READ_A,  0,  0, '0, ST_OK,  0,  0, '0);
        plan_checked(MODE_READ_B,  3,  3, '0, ST_OK,  3,  3, '0);
        plan_checked(MODE_READ_A,  4,  0, '0, ST_OOB, 4,  0, '0);
        plan_checked(MODE_WRITE_B, 2, 15, 32'h1234_5678, ST_OOB, 2, 15, '0);
        plan_checked(MODE_WRITE_A, 0,  0, 32'h7FFF_FFFF, ST_OK, 0, 0, '0);
        plan_checked(MODE_WRITE_A, 3,  3, 32'h8000_0000, ST_OK, 3, 3, '0);
        plan_checked(MODE_WRITE_B, 0,  0, 32'hFFFF_FFFF, ST_OK, 0, 0, '0);
        plan_checked(MODE_WRITE_B, 3,  3, 32'h8000_0000, ST_OK, 3, 3, '0);
        plan_checked(MODE_READ_A,  3,  3, '0, ST_OK, 3, 3, 32'h8000_0000);
        // Product of the corners wraps.
        plan_word(MODE_COMPUTE, 0, 0, '0);
        plan_word(MODE_SPARE_5, 1, 2, 32'hDEAD_BEEF);
        plan_word(MODE_SPARE_6, 15, 15, '0);
        plan_word(MODE_SPARE_7, 0, 0, 32'hFFFF_FFFF);
        // Element-wise add with overflow.
        plan_reg(CFG_OPERATION, OP_ADD);
        plan_word(MODE_COMPUTE, 0, 0, '0);
        // Shapes that differ for an add.
        plan_reg(CFG_A_ROWS, 3);
        plan_checked(MODE_COMPUTE, 0, 0, '0, ST_MISMATCH, 0, 0, '0);
        // Matching shapes that overflow the store.
        plan_reg(CFG_A_ROWS, 16);
        plan_reg(CFG_B_ROWS, 16);
        plan_checked(MODE_WRITE_A, 0, 0, 32'h0000_0001, ST_TOO_LARGE, 0, 0, '0);
        plan_checked(MODE_COMPUTE, 0, 0, '0, ST_TOO_LARGE, 0, 0, '0);
        // A 16x1 times 1x16 fits in A and B but not in the product.
        plan_reg(CFG_OPERATION, OP_MUL);
        plan_reg(CFG_A_COLS, 1);
        plan_reg(CFG_B_ROWS, 1);
        plan_reg(CFG_B_COLS, 16);
        plan_checked(MODE_COMPUTE, 0, 0, '0, ST_TOO_LARGE, 0, 0, '0);
        // 16x1 times 1x1 gives the largest result count.
        plan_reg(CFG_B_COLS, 1);
        plan_checked(MODE_WRITE_A, 15, 0, 32'h1234_5678, ST_OK, 15, 0, '0);
        plan_word(MODE_COMPUTE, 0, 0, '0);
        plan_reg(CFG_B_ROWS, 2);
        plan_checked(MODE_COMPUTE, 0, 0, '0, ST_MISMATCH, 0, 0, '0);
        // No rows in A: every access to A is out of bounds, the product is empty.
        plan_reg(CFG_A_ROWS, 0);
        plan_reg(CFG_B_ROWS, 1);
        plan_checked(MODE_READ_A, 0, 0, '0, ST_OOB, 0, 0, '0);
        plan_word(MODE_COMPUTE, 0, 0, '0);
        // Empty inner dimension: a full 4x4 result of zeros.
        plan_reg(CFG_A_ROWS, 4);
        plan_reg(CFG_A_COLS, 0);
        plan_reg(CFG_B_ROWS, 0);
        plan_reg(CFG_B_COLS, 4);
        plan_word(MODE_COMPUTE, 0, 0, '0);

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        for (int s = 0; s < directed_plan.size(); s++)
        begin
            step = directed_plan[s];
            if (step.kind == STEP_REG)
            begin
                drain_block();
                write_register(step.reg_index, step.reg_value);
            end
            else
            begin
                send_word(step.cmd, pick_gap(1'b0));
                // The typed word stands in for the one the model just queued.
                if (step.typed)
                begin
                    void'(awaited_results.pop_back());
                    awaited_results.push_back(step.typed_word);
                end
            end
        end

        // Random phases: each starts from an idle block with a fresh shape.
        // Most shapes are valid, so A and B get loaded, computed and read;
        // the rest are mismatched, oversized or empty and get random words.
        words_accepted = 0;
        phase          = 0;
        while (words_accepted < RANDOM_WORDS)
        begin
            drain_block();
            steady      = (phase % 4 == 3);
            sink_steady = steady;

            shape_kind = $urandom_range(0, 9);
            op         = $urandom_range(0, 1);
            if (shape_kind < 7)
            begin
                ar = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 16) : $urandom_range(1, 4);
                ac = $urandom_range(1, MAX_ELEMENTS / ar);
                if (op == OP_ADD)
                begin
                    br = ar;
                    bc = ac;
                end
                else
                begin
                    br = ac;
                    bc = $urandom_range(1, MAX_ELEMENTS / ((ac > ar) ? ac : ar));
                end
            end
            else if (shape_kind == 7)
            begin
                ar = $urandom_range(1, 4);
                ac = $urandom_range(1, 4);
                br = ac + 1;
                bc = ar;
            end
            else if (shape_kind == 8)
            begin
                ar = $urandom_range(5, 16);
                ac = $urandom_range(4, 16);
                br = ac;
                bc = ar;
            end
            else
            begin
                ar = $urandom_range(0, 4);
                ac = (ar == 0) ? $urandom_range(0, 4) : 0;
                br = (op == OP_ADD) ? ar : ac;
                bc = (op == OP_ADD) ? ac : $urandom_range(0, 4);
            end
            write_register(CFG_OPERATION, op);
            write_register(CFG_A_ROWS, ar);
            write_register(CFG_A_COLS, ac);
            write_register(CFG_B_ROWS, br);
            write_register(CFG_B_COLS, bc);

            // Once, the sink holds off while the loads keep coming.
            if (phase == 2)
                sink_hold_request = 1'b1;

            if (shape_kind < 7)
            begin
                for (int unsigned e = 0; e < ar * ac; e++)
                begin
                    if (!steady && $urandom_range(0, 9) == 0)
                        send_word(make_cmd($urandom_range(0, 7), $urandom_range(0, 15),
                                           $urandom_range(0, 15), pick_value()), pick_gap(1'b0));
                    send_word(make_cmd(MODE_WRITE_A, e / ac, e % ac, pick_value()),
                              pick_gap(steady));
                end
                for (int unsigned e = 0; e < br * bc; e++)
                    send_word(make_cmd(MODE_WRITE_B, e / bc, e % bc, pick_value()),
                              pick_gap(steady));
                send_word(make_cmd(MODE_COMPUTE, 0, 0, '0), pick_gap(steady));
                reads = $urandom_range(2, 4);
                repeat (reads)
                begin
                    use_b = $urandom_range(0, 1);
                    rows  = use_b ? br : ar;
                    cols  = use_b ? bc : ac;
                    if ($urandom_range(0, 4) == 0)
                        send_word(make_cmd(use_b ? MODE_READ_B : MODE_READ_A,
                                           $urandom_range(0, 15), $urandom_range(0, 15), '0),
                                  pick_gap(steady));
                    else
                        send_word(make_cmd(use_b ? MODE_READ_B : MODE_READ_A,
                                           $urandom_range(0, rows - 1),
                                           $urandom_range(0, cols - 1), '0),
                                  pick_gap(steady));
                end
                send_word(make_cmd(MODE_COMPUTE, $urandom_range(0, 15),
                                   $urandom_range(0, 15), pick_value()), pick_gap(steady));
            end
            else
            begin
                repeat (6)
                    send_word(make_cmd($urandom_range(0, 7), $urandom_range(0, 15),
                                       $urandom_range(0, 15), pick_value()), pick_gap(steady));
                send_word(make_cmd(MODE_COMPUTE, 0, 0, '0), pick_gap(steady));
            end
            phase++;
        end

        drain_block();
        if (error_count == 0 && awaited_results.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

>>> files.f
rtl/smam_pkg.sv
rtl/smam_store.sv
rtl/small_matrix_add_multiply.sv
verif/small_matrix_add_multiply_test.sv
